### rtl/rsi_pkg.sv
package rsi_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int QW            = 32;
	localparam int RAD_W         = 31;
	localparam int CFG_IDX_W     = 8;

	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 8'd3;

	localparam logic [RAD_W-1:0] RADIUS_RST = 31'd65536;
	localparam logic [QW-1:0]    SAT_MAX    = 32'h7FFF_FFFF;
	localparam logic [QW-1:0]    SAT_MIN    = 32'h8000_0000;

	// quadratic term widths
	localparam int A_W  = 64;
	localparam int B_W  = 67;
	localparam int D_W  = 132;
	localparam int S_W  = 66;
	localparam int RT_W = B_W + 2;
	localparam int PD_W = QW + 1;

	typedef logic [QW-1:0] q_t;

	typedef struct packed {
		q_t [2:0] o;
		q_t [2:0] d;
		q_t       lo;
		q_t       hi;
	} ray_side_t;

	typedef struct packed {
		logic [A_W-1:0] a;
		logic [B_W-1:0] b;
		logic           ok;
		ray_side_t      ray;
	} root_side_t;

	typedef struct packed {
		logic      ok;
		ray_side_t ray;
	} sel_side_t;

	typedef struct packed {
		logic     hit;
		q_t       t;
		q_t [2:0] p;
		q_t [2:0] d;
	} shade_side_t;

endpackage

### rtl/rsi_if.sv
interface rsi_ray_if import rsi_pkg::*;;
	logic       valid;
	logic       ready;
	logic signed [QW-1:0] origin_x;
	logic signed [QW-1:0] origin_y;
	logic signed [QW-1:0] origin_z;
	logic signed [QW-1:0] dir_x;
	logic signed [QW-1:0] dir_y;
	logic signed [QW-1:0] dir_z;
	logic signed [QW-1:0] t_lower;
	logic signed [QW-1:0] t_upper;

	modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		t_lower, t_upper, input ready);
	modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		t_lower, t_upper, output ready);
endinterface

interface rsi_hit_if import rsi_pkg::*;;
	logic       valid;
	logic       ready;
	logic       is_hit;
	logic signed [QW-1:0] hit_t;
	logic signed [QW-1:0] point_x;
	logic signed [QW-1:0] point_y;
	logic signed [QW-1:0] point_z;
	logic signed [QW-1:0] normal_x;
	logic signed [QW-1:0] normal_y;
	logic signed [QW-1:0] normal_z;
	logic signed [QW-1:0] local_x;
	logic signed [QW-1:0] local_y;
	logic signed [QW-1:0] local_z;
	logic       facing_flip;

	modport source (output valid, is_hit, hit_t, point_x, point_y, point_z, normal_x,
		normal_y, normal_z, local_x, local_y, local_z, facing_flip, input ready);
	modport sink (input valid, is_hit, hit_t, point_x, point_y, point_z, normal_x,
		normal_y, normal_z, local_x, local_y, local_z, facing_flip, output ready);
endinterface

interface rsi_cfg_if import rsi_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [QW-1:0]        data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### rtl/rsi_quad.sv
module rsi_quad import rsi_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  ray_side_t        in_side,
	input  q_t [2:0]         center,
	input  logic [RAD_W-1:0] radius,
	output logic             out_valid,
	output logic [D_W-1:0]   out_d,
	output root_side_t       out_side
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	ray_side_t ray_s1, ray_s2, ray_s3, ray_s4, ray_s5, ray_s6, ray_s7;

	logic signed [32:0] oc_s1 [3];
	logic signed [63:0] dd_s2 [3];
	logic signed [64:0] od_s2 [3];
	logic signed [65:0] oo_s2 [3];
	logic [61:0]        rr_s2;

	logic [A_W-1:0]        a_s3, a_s4, a_s5, a_s6, a_s7;
	logic signed [B_W-1:0] b_s3, b_s4, b_s5, b_s6, b_s7;
	logic signed [67:0]    c_s3;

	logic [64:0] bm_s4;
	logic [65:0] cm_s4;
	logic        cneg_s4, cneg_s5, cneg_s6;

	logic [63:0] bhh_s5;
	logic [64:0] bhl_s5;
	logic [65:0] bll_s5;
	logic [64:0] ac_hh_s5, ac_hl_s5, ac_lh_s5, ac_ll_s5;

	logic [D_W-1:0] b2_s6, ac_s6;
	logic signed [D_W:0] d_s7;
	logic ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7} <= '0;
		end else if (en) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7} <=
				{in_valid, v_s1, v_s2, v_s3, v_s4, v_s5, v_s6};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				oc_s1[i] <= $signed({in_side.o[i][QW-1], in_side.o[i]})
					- $signed({center[i][QW-1], center[i]});
				dd_s2[i] <= $signed(ray_s1.d[i]) * $signed(ray_s1.d[i]);
				od_s2[i] <= oc_s1[i] * $signed(ray_s1.d[i]);
				oo_s2[i] <= oc_s1[i] * oc_s1[i];
			end
			ray_s1 <= in_side;
			rr_s2  <= radius * radius;
			ray_s2 <= ray_s1;

			a_s3   <= 64'(dd_s2[0]) + 64'(dd_s2[1]) + 64'(dd_s2[2]);
			b_s3   <= 67'(od_s2[0]) + 67'(od_s2[1]) + 67'(od_s2[2]);
			c_s3   <= 68'(oo_s2[0]) + 68'(oo_s2[1]) + 68'(oo_s2[2]) - 68'(rr_s2);
			ray_s3 <= ray_s2;

			bm_s4   <= b_s3[B_W-1] ? 65'(-b_s3) : 65'(b_s3);
			cm_s4   <= c_s3[67] ? 66'(-c_s3) : 66'(c_s3);
			cneg_s4 <= c_s3[67];
			a_s4    <= a_s3;
			b_s4    <= b_s3;
			ray_s4  <= ray_s3;

			// split products into 32/33 bit pieces
			bhh_s5   <= bm_s4[64:33] * bm_s4[64:33];
			bhl_s5   <= bm_s4[64:33] * bm_s4[32:0];
			bll_s5   <= bm_s4[32:0] * bm_s4[32:0];
			ac_hh_s5 <= a_s4[63:32] * cm_s4[65:33];
			ac_hl_s5 <= a_s4[63:32] * cm_s4[32:0];
			ac_lh_s5 <= a_s4[31:0] * cm_s4[65:33];
			ac_ll_s5 <= a_s4[31:0] * cm_s4[32:0];
			cneg_s5  <= cneg_s4;
			a_s5     <= a_s4;
			b_s5     <= b_s4;
			ray_s5   <= ray_s4;

			b2_s6   <= (D_W'(bhh_s5) << 66) + (D_W'(bhl_s5) << 34) + D_W'(bll_s5);
			ac_s6   <= (D_W'(ac_hh_s5) << 65) + (D_W'(ac_hl_s5) << 32)
				+ (D_W'(ac_lh_s5) << 33) + D_W'(ac_ll_s5);
			cneg_s6 <= cneg_s5;
			a_s6    <= a_s5;
			b_s6    <= b_s5;
			ray_s6  <= ray_s5;

			d_s7   <= cneg_s6 ? (133'(b2_s6) + 133'(ac_s6)) : (133'(b2_s6) - 133'(ac_s6));
			a_s7   <= a_s6;
			b_s7   <= b_s6;
			ray_s7 <= ray_s6;
		end
	end

	assign ok        = !d_s7[D_W] && (d_s7 != '0) && (a_s7 != '0);
	assign out_valid = v_s7;
	assign out_d     = ok ? d_s7[D_W-1:0] : '0;
	assign out_side  = '{a: a_s7, b: b_s7, ok: ok, ray: ray_s7};

endmodule

### rtl/rsi_sqrt_pipe.sv
module rsi_sqrt_pipe import rsi_pkg::*; #(
	parameter int SW = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  logic [D_W-1:0] in_d,
	input  logic [SW-1:0]  in_side,
	output logic           out_valid,
	output logic [S_W-1:0] out_s,
	output logic [SW-1:0]  out_side
);

	logic [D_W-1:0] rem_s [S_W];
	logic [D_W-1:0] res_s [S_W];
	logic [SW-1:0]  side_s [S_W];
	logic           v_s [S_W];

	logic [D_W-1:0] cur_rem [S_W];
	logic [D_W-1:0] cur_res [S_W];
	logic [SW-1:0]  cur_side [S_W];
	logic           cur_v [S_W];

	for (genvar j = 0; j < S_W; j++) begin : g_stage
		localparam logic [D_W-1:0] BIT = D_W'(1) << (2 * (S_W - 1 - j));

		if (j == 0) begin : g_first
			assign cur_rem[j]  = in_d;
			assign cur_res[j]  = '0;
			assign cur_side[j] = in_side;
			assign cur_v[j]    = in_valid;
		end else begin : g_next
			assign cur_rem[j]  = rem_s[j-1];
			assign cur_res[j]  = res_s[j-1];
			assign cur_side[j] = side_s[j-1];
			assign cur_v[j]    = v_s[j-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (en) begin
				v_s[j] <= cur_v[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (cur_rem[j] >= cur_res[j] + BIT) begin
					rem_s[j] <= cur_rem[j] - cur_res[j] - BIT;
					res_s[j] <= (cur_res[j] >> 1) + BIT;
				end else begin
					rem_s[j] <= cur_rem[j];
					res_s[j] <= cur_res[j] >> 1;
				end
				side_s[j] <= cur_side[j];
			end
		end
	end

	assign out_valid = v_s[S_W-1];
	assign out_s     = res_s[S_W-1][S_W-1:0];
	assign out_side  = side_s[S_W-1];

endmodule

### rtl/rsi_div_pipe.sv
module rsi_div_pipe import rsi_pkg::*; #(
	parameter int LANES = 1,
	parameter int NW    = 64,
	parameter int DW    = 32,
	parameter int SW    = 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [LANES-1:0][NW-1:0]   in_num,
	input  logic [LANES-1:0]           in_neg,
	input  logic [DW-1:0]              in_den,
	input  logic [SW-1:0]              in_side,
	output logic                       out_valid,
	output logic [LANES-1:0][QW-1:0]   out_q,
	output logic [SW-1:0]              out_side
);

	localparam int CW = (NW > DW + QW) ? NW : DW + QW;

	logic [LANES-1:0][NW-1:0] rem_s [QW+1];
	logic [LANES-1:0][QW-1:0] q_s [QW+1];
	logic [LANES-1:0]         ovf_s [QW+1];
	logic [LANES-1:0]         neg_s [QW+1];
	logic [DW-1:0]            den_s [QW+1];
	logic [SW-1:0]            side_s [QW+1];
	logic                     v_s [QW+1];

	logic [LANES-1:0][QW-1:0] q_q;
	logic [SW-1:0]            side_q;
	logic                     v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	// quotient must fit in QW bits, else saturate
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < LANES; l++) begin
				rem_s[0][l] <= in_num[l];
				ovf_s[0][l] <= CW'(in_num[l]) >= (CW'(in_den) << QW);
			end
			q_s[0]    <= '0;
			neg_s[0]  <= in_neg;
			den_s[0]  <= in_den;
			side_s[0] <= in_side;
		end
	end

	for (genvar j = 0; j < QW; j++) begin : g_step
		localparam int K = QW - 1 - j;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else if (en) begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < LANES; l++) begin
					if (CW'(rem_s[j][l]) >= (CW'(den_s[j]) << K)) begin
						rem_s[j+1][l] <= NW'(CW'(rem_s[j][l]) - (CW'(den_s[j]) << K));
						q_s[j+1][l]   <= q_s[j][l] | (QW'(1) << K);
					end else begin
						rem_s[j+1][l] <= rem_s[j][l];
						q_s[j+1][l]   <= q_s[j][l];
					end
				end
				ovf_s[j+1]  <= ovf_s[j];
				neg_s[j+1]  <= neg_s[j];
				den_s[j+1]  <= den_s[j];
				side_s[j+1] <= side_s[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < LANES; l++) begin
				if (!neg_s[QW][l]) begin
					q_q[l] <= (ovf_s[QW][l] || q_s[QW][l][QW-1]) ? SAT_MAX : q_s[QW][l];
				end else if (ovf_s[QW][l] || (q_s[QW][l][QW-1] && (|q_s[QW][l][QW-2:0]))) begin
					q_q[l] <= SAT_MIN;
				end else begin
					q_q[l] <= -q_s[QW][l];
				end
			end
			side_q <= side_s[QW];
		end
	end

	assign out_valid = v_q;
	assign out_q     = q_q;
	assign out_side  = side_q;

endmodule

### rtl/ray_sphere_intersect.sv
// Ray/sphere intersector, signed fixed point with FRAC_BITS fractional bits.
// Streams one ray per clock; every ray yields exactly one result, in order,
// after passing in turn through the quadratic stage forming a, b, c and the
// discriminant, the bit-per-stage square root, the root numerators, the two
// root dividers, hit select and hit point, the six radius dividers, and the
// facing test and the output register.
// When the result at the output is not taken, the whole pipeline holds and
// the input is not ready. Sphere center and radius are written through the
// cfg channel (index 0..2 center x/y/z, 3 radius) and must only change while
// no ray is in flight. A miss returns is_hit low with all other fields zero.
module ray_sphere_intersect import rsi_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	rsi_ray_if.sink   ray,
	rsi_hit_if.source res,
	rsi_cfg_if.sink   cfg
);

	localparam int RN_W = RT_W + FRAC_BITS;
	localparam int NL_W = PD_W + FRAC_BITS;

	q_t [2:0]         center_q;
	logic [RAD_W-1:0] radius_q;
	logic [RAD_W-1:0] div;
	logic             en;
	logic             out_v_q;

	ray_side_t  ray_in;
	logic       qd_v;
	logic [D_W-1:0] qd_d;
	root_side_t qd_side;

	logic       sq_v;
	logic [S_W-1:0] sq_s;
	root_side_t sq_side;

	// root numerators
	logic                   v_s1, v_s2;
	logic signed [RT_W-1:0] nn_s1, nf_s1;
	root_side_t             rs_s1;
	logic [RT_W-1:0]        nm_s2, fm_s2;
	logic                   nneg_s2, fneg_s2;
	logic [A_W-1:0]         a_s2;
	sel_side_t              sel_s2;
	logic [1:0][RN_W-1:0]   rnum;

	logic            rd_v;
	logic [1:0][QW-1:0] rd_q;
	sel_side_t       rd_side;

	// hit select, point and divider inputs
	logic               v_s3, v_s4, v_s5, v_s6;
	logic               hn, hf;
	logic               hit_s3, hit_s4, hit_s5;
	q_t                 t_s3, t_s4, t_s5;
	ray_side_t          ray_s3, ray_s4;
	logic signed [63:0] pr_s4 [3];
	logic signed [64:0] psum [3];
	q_t [2:0]           p_s5;
	q_t [2:0]           d_s5;
	logic signed [PD_W-1:0] nd_c [3];
	logic signed [PD_W-1:0] pe_c [3];
	logic [2:0][PD_W-1:0] nm_s6, lm_s6;
	logic [2:0]         nneg_s6, lneg_s6;
	shade_side_t        sh_s6;
	logic [5:0][NL_W-1:0] nlnum;

	logic             nl_v;
	logic [5:0][QW-1:0] nl_q;
	shade_side_t      nl_side;

	// facing test and output
	logic               v_s7;
	logic signed [63:0] dp_s7 [3];
	q_t [2:0]           n_s7, l_s7;
	shade_side_t        sh_s7;
	logic signed [65:0] dot;
	logic               flip;

	logic       hit_q, flip_q;
	q_t         t_q;
	q_t [2:0]   p_q, n_q, l_q;

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= '0;
			radius_q <= RADIUS_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_CENTER_X: center_q[0] <= cfg.data;
				REG_CENTER_Y: center_q[1] <= cfg.data;
				REG_CENTER_Z: center_q[2] <= cfg.data;
				REG_RADIUS:   radius_q    <= cfg.data[RAD_W-1:0];
				default: ;
			endcase
		end
	end

	assign div = (radius_q == '0) ? RAD_W'(1) : radius_q;

	assign en        = !out_v_q || res.ready;
	assign ray.ready = en;

	assign ray_in.o  = {ray.origin_z, ray.origin_y, ray.origin_x};
	assign ray_in.d  = {ray.dir_z, ray.dir_y, ray.dir_x};
	assign ray_in.lo = ray.t_lower;
	assign ray_in.hi = ray.t_upper;

	rsi_quad u_quad (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (ray.valid),
		.in_side   (ray_in),
		.center    (center_q),
		.radius    (radius_q),
		.out_valid (qd_v),
		.out_d     (qd_d),
		.out_side  (qd_side)
	);

	rsi_sqrt_pipe #(
		.SW ($bits(root_side_t))
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (qd_v),
		.in_d      (qd_d),
		.in_side   (qd_side),
		.out_valid (sq_v),
		.out_s     (sq_s),
		.out_side  (sq_side)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7} <= '0;
		end else if (en) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7} <=
				{sq_v, v_s1, rd_v, v_s3, v_s4, v_s5, nl_v};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nn_s1 <= -RT_W'($signed(sq_side.b)) - RT_W'(sq_s);
			nf_s1 <= -RT_W'($signed(sq_side.b)) + RT_W'(sq_s);
			rs_s1 <= sq_side;

			nm_s2   <= nn_s1[RT_W-1] ? RT_W'(-nn_s1) : RT_W'(nn_s1);
			fm_s2   <= nf_s1[RT_W-1] ? RT_W'(-nf_s1) : RT_W'(nf_s1);
			nneg_s2 <= nn_s1[RT_W-1];
			fneg_s2 <= nf_s1[RT_W-1];
			a_s2    <= rs_s1.a;
			sel_s2  <= '{ok: rs_s1.ok, ray: rs_s1.ray};
		end
	end

	assign rnum[0] = RN_W'(nm_s2) << FRAC_BITS;
	assign rnum[1] = RN_W'(fm_s2) << FRAC_BITS;

	rsi_div_pipe #(
		.LANES (2),
		.NW    (RN_W),
		.DW    (A_W),
		.SW    ($bits(sel_side_t))
	) u_root_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.in_num    (rnum),
		.in_neg    ({fneg_s2, nneg_s2}),
		.in_den    (a_s2),
		.in_side   (sel_s2),
		.out_valid (rd_v),
		.out_q     (rd_q),
		.out_side  (rd_side)
	);

	// near root first, far root second
	assign hn = rd_side.ok && ($signed(rd_q[0]) > $signed(rd_side.ray.lo))
		&& ($signed(rd_q[0]) < $signed(rd_side.ray.hi));
	assign hf = rd_side.ok && ($signed(rd_q[1]) > $signed(rd_side.ray.lo))
		&& ($signed(rd_q[1]) < $signed(rd_side.ray.hi));

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			psum[i] = 65'($signed(ray_s4.o[i])) + 65'(pr_s4[i] >>> FRAC_BITS);
			nd_c[i] = $signed({p_s5[i][QW-1], p_s5[i]})
				- $signed({center_q[i][QW-1], center_q[i]});
			pe_c[i] = $signed({p_s5[i][QW-1], p_s5[i]});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s3 <= hn || hf;
			t_s3   <= hn ? rd_q[0] : rd_q[1];
			ray_s3 <= rd_side.ray;

			for (int i = 0; i < 3; i++) begin
				pr_s4[i] <= $signed(t_s3) * $signed(ray_s3.d[i]);
				if (psum[i][64:QW-1] != {(66-QW){psum[i][64]}}) begin
					p_s5[i] <= psum[i][64] ? SAT_MIN : SAT_MAX;
				end else begin
					p_s5[i] <= psum[i][QW-1:0];
				end
				nm_s6[i]   <= nd_c[i][PD_W-1] ? PD_W'(-nd_c[i]) : PD_W'(nd_c[i]);
				lm_s6[i]   <= pe_c[i][PD_W-1] ? PD_W'(-pe_c[i]) : PD_W'(pe_c[i]);
				nneg_s6[i] <= nd_c[i][PD_W-1];
				lneg_s6[i] <= pe_c[i][PD_W-1];
			end
			hit_s4 <= hit_s3;
			t_s4   <= t_s3;
			ray_s4 <= ray_s3;

			hit_s5 <= hit_s4;
			t_s5   <= t_s4;
			d_s5   <= ray_s4.d;

			sh_s6 <= '{hit: hit_s5, t: t_s5, p: p_s5, d: d_s5};
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_nlnum
		assign nlnum[i]   = NL_W'(nm_s6[i]) << FRAC_BITS;
		assign nlnum[i+3] = NL_W'(lm_s6[i]) << FRAC_BITS;
	end

	rsi_div_pipe #(
		.LANES (6),
		.NW    (NL_W),
		.DW    (RAD_W),
		.SW    ($bits(shade_side_t))
	) u_rad_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s6),
		.in_num    (nlnum),
		.in_neg    ({lneg_s6, nneg_s6}),
		.in_den    (div),
		.in_side   (sh_s6),
		.out_valid (nl_v),
		.out_q     (nl_q),
		.out_side  (nl_side)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dp_s7[i] <= $signed(nl_side.d[i]) * $signed(nl_q[i]);
			end
			n_s7  <= nl_q[2:0];
			l_s7  <= nl_q[5:3];
			sh_s7 <= nl_side;
		end
	end

	assign dot  = 66'(dp_s7[0]) + 66'(dp_s7[1]) + 66'(dp_s7[2]);
	assign flip = !dot[65] && (dot != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (sh_s7.hit) begin
				hit_q  <= 1'b1;
				t_q    <= sh_s7.t;
				p_q    <= sh_s7.p;
				n_q    <= n_s7;
				l_q    <= l_s7;
				flip_q <= flip;
			end else begin
				hit_q  <= 1'b0;
				t_q    <= '0;
				p_q    <= '0;
				n_q    <= '0;
				l_q    <= '0;
				flip_q <= 1'b0;
			end
		end
	end

	assign res.valid       = out_v_q;
	assign res.is_hit      = hit_q;
	assign res.hit_t       = t_q;
	assign res.point_x     = p_q[0];
	assign res.point_y     = p_q[1];
	assign res.point_z     = p_q[2];
	assign res.normal_x    = n_q[0];
	assign res.normal_y    = n_q[1];
	assign res.normal_z    = n_q[2];
	assign res.local_x     = l_q[0];
	assign res.local_y     = l_q[1];
	assign res.local_z     = l_q[2];
	assign res.facing_flip = flip_q;

endmodule
